@@ rtl/mdr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the midpoint dead-reckoning pose block.
// No dependencies; every other file imports this package.

package mdr_pkg;

    // Field widths fixed by the word format
    localparam int DELTA_W   = 24;
    localparam int DHEAD_W   = 16;
    localparam int POS_W     = 48;
    localparam int HEAD_W    = 40;
    localparam int MID_W     = 17;   // midpoint angle in 1/131072 turn
    localparam int PROD_W    = 57;   // delta times gain reciprocal
    localparam int PRE_W     = 33;   // prescaled value with 8 guard bits
    localparam int VEC_W     = 36;   // rotator working width
    localparam int GUARD_W   = 8;

    // Word kinds
    localparam logic [1:0] KIND_DELTA = 2'd0;
    localparam logic [1:0] KIND_ZERO  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    // Fault codes
    localparam logic [1:0] FAULT_OK    = 2'd0;
    localparam logic [1:0] FAULT_BOTH  = 2'd1;
    localparam logic [1:0] FAULT_LEFT  = 2'd2;
    localparam logic [1:0] FAULT_RIGHT = 2'd3;

    // Converged CORDIC gain reciprocal, Q32
    localparam logic signed [PRE_W-1:0] INV_GAIN_Q32 = 33'sd2608131496;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_ROTATE,
        ST_ACCUM,
        ST_PUBLISH
    } state_t;

    // Rotator control from the sequencer
    typedef struct packed {
        logic load;
        logic mul_x;
        logic mul_y;
        logic step;
    } cordic_ctl_t;

    // Arctangent of 2^-i in Q32 turns
    function automatic logic [31:0] atan_q32(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2F9;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/mdr_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input and result words.
// Depends on mdr_pkg for field widths.

interface mdr_in_if;
    import mdr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [1:0]                kind;
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;
    logic signed [DHEAD_W-1:0] delta_heading;
    logic                      left_ok;
    logic                      right_ok;

    modport source (
        output valid, kind, delta_x, delta_y, delta_heading, left_ok, right_ok,
        input  ready
    );
    modport sink (
        input  valid, kind, delta_x, delta_y, delta_heading, left_ok, right_ok,
        output ready
    );
endinterface

interface mdr_out_if;
    import mdr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [HEAD_W-1:0] heading_out;
    logic                     killed;
    logic [1:0]               fault_code;

    modport source (
        output valid, pos_x, pos_y, heading_out, killed, fault_code,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, heading_out, killed, fault_code,
        output ready
    );
endinterface

@@ rtl/mdr_cordic.sv @@
`timescale 1ns / 1ps
// Iterative vector rotator: angle reduction, gain prescale on one shared
// multiplier, then one CORDIC micro-rotation per step. Depends on mdr_pkg.

module mdr_cordic #(
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  mdr_pkg::cordic_ctl_t                   ctl,
    input  logic signed [mdr_pkg::DELTA_W-1:0]     delta_x,
    input  logic signed [mdr_pkg::DELTA_W-1:0]     delta_y,
    input  logic [mdr_pkg::MID_W-1:0]              mid,
    output logic                                   last,
    output logic signed [mdr_pkg::POS_W-1:0]       rot_x,
    output logic signed [mdr_pkg::POS_W-1:0]       rot_y
);
    import mdr_pkg::*;

    localparam int AFB     = ANGLE_FRAC_BITS;
    localparam int ZW      = AFB + 1;
    localparam int STG_W   = $clog2(CORDIC_STAGES);
    localparam int ATAN_SH = 32 - AFB;
    localparam int RND_W   = VEC_W - GUARD_W;

    logic [AFB-1:0]            angle;
    logic [AFB:0]              angle_bias;
    logic [1:0]                quad;
    logic [AFB-1:0]            resid;

    logic signed [DELTA_W-1:0] dx_reg;
    logic signed [DELTA_W-1:0] dy_reg;
    logic [1:0]                quad_reg;
    logic signed [ZW-1:0]      z_reg;
    logic signed [VEC_W-1:0]   x_reg;
    logic signed [VEC_W-1:0]   y_reg;
    logic [STG_W-1:0]          stage_reg;

    logic signed [DELTA_W-1:0] mul_op;
    logic signed [PROD_W-1:0]  prod;
    logic signed [VEC_W-1:0]   pre;
    logic signed [VEC_W-1:0]   x_sh;
    logic signed [VEC_W-1:0]   y_sh;
    logic [32:0]               atan_rnd;
    logic signed [ZW-1:0]      atan_step;
    logic signed [VEC_W-1:0]   x_rnd;
    logic signed [VEC_W-1:0]   y_rnd;

    // Map the 17-bit midpoint onto the angle grid
    generate
        if (AFB >= MID_W) begin : g_widen
            assign angle = AFB'(mid) << (AFB - MID_W);
        end else begin : g_narrow
            localparam int NS = MID_W - AFB;
            logic [MID_W:0] mid_rnd;
            assign mid_rnd = {1'b0, mid} + ((MID_W + 1)'(1) << (NS - 1));
            assign angle   = AFB'(mid_rnd >> NS);
        end
    endgenerate

    // Quadrant step leaves a residual within one eighth turn
    assign angle_bias = {1'b0, angle} + ((AFB + 1)'(1) << (AFB - 3));
    assign quad       = angle_bias[AFB-1:AFB-2];
    assign resid      = angle - {quad, {(AFB - 2){1'b0}}};

    // Shared multiplier: delta times gain reciprocal, keep 8 guard bits
    assign mul_op = ctl.mul_y ? dy_reg : dx_reg;
    assign prod   = mul_op * INV_GAIN_Q32;
    assign pre    = {{(VEC_W - PRE_W){prod[PROD_W-1]}}, prod[PROD_W-1:PROD_W-PRE_W]};

    // Shared shift and add for one micro-rotation
    assign x_sh      = x_reg >>> stage_reg;
    assign y_sh      = y_reg >>> stage_reg;
    assign atan_rnd  = {1'b0, atan_q32(5'(stage_reg))} + (33'd1 << (ATAN_SH - 1));
    assign atan_step = atan_rnd[32:ATAN_SH];
    assign last      = (stage_reg == STG_W'(CORDIC_STAGES - 1));

    // Drop guard bits, rounding half up
    assign x_rnd = x_reg + VEC_W'(128);
    assign y_rnd = y_reg + VEC_W'(128);
    assign rot_x = {{(POS_W - RND_W){x_rnd[VEC_W-1]}}, x_rnd[VEC_W-1:GUARD_W]};
    assign rot_y = {{(POS_W - RND_W){y_rnd[VEC_W-1]}}, y_rnd[VEC_W-1:GUARD_W]};

    // Stage counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (ctl.load)
        begin
            stage_reg <= '0;
        end
        else if (ctl.step && !last)
        begin
            stage_reg <= stage_reg + STG_W'(1);
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            dx_reg   <= delta_x;
            dy_reg   <= delta_y;
            quad_reg <= quad;
            z_reg    <= {resid[AFB-1], resid};
        end
        else if (ctl.mul_x)
        begin
            case (quad_reg)
                2'd0:    x_reg <= pre;
                2'd1:    y_reg <= pre;
                2'd2:    x_reg <= -pre;
                default: y_reg <= -pre;
            endcase
        end
        else if (ctl.mul_y)
        begin
            case (quad_reg)
                2'd0:    y_reg <= pre;
                2'd1:    x_reg <= -pre;
                2'd2:    y_reg <= -pre;
                default: x_reg <= pre;
            endcase
        end
        else if (ctl.step)
        begin
            if (!z_reg[ZW-1])
            begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - atan_step;
            end
            else
            begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + atan_step;
            end
        end
    end

endmodule

@@ rtl/midpoint_dead_reckoning_pose.sv @@
`timescale 1ns / 1ps
// Top level: sequencer, pose accumulators, status and result register.
// Depends on mdr_pkg, mdr_if and mdr_cordic.
//
//   Channel  Dir  Handshake       Carries
//   in_ch    in   valid / ready   kind, delta_x, delta_y, delta_heading, flags
//   out_ch   out  valid / ready   pos_x, pos_y, heading_out, killed, fault_code
//
// A valid motion word passes through two multiplier passes, one rotation
// step per stage, an accumulate and a publish state. Input is ready again
// once publish returns the sequencer to idle, so the block takes no new word
// until then. Other words go straight from idle to publish. Reset clears the
// pose, status and sequencer. A stalled result holds the sequencer in its
// publish state; input is taken only while idle.

module midpoint_dead_reckoning_pose #(
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    mdr_in_if.sink    in_ch,
    mdr_out_if.source out_ch
);
    import mdr_pkg::*;

    state_t                   state_reg;
    state_t                   state_next;

    logic signed [POS_W-1:0]  x_acc_reg;
    logic signed [POS_W-1:0]  y_acc_reg;
    logic signed [HEAD_W-1:0] head_acc_reg;
    logic                     kill_reg;
    logic [1:0]               fault_reg;
    logic signed [DHEAD_W-1:0] dth_reg;

    logic                     out_valid_reg;
    logic signed [POS_W-1:0]  out_x_reg;
    logic signed [POS_W-1:0]  out_y_reg;
    logic signed [HEAD_W-1:0] out_head_reg;
    logic                     out_kill_reg;
    logic [1:0]               out_fault_reg;

    logic                     accept;
    logic                     is_delta;
    logic                     flags_ok;
    logic                     publish;
    logic                     accum;
    logic                     out_free;
    cordic_ctl_t              ctl;
    logic                     last;
    logic [MID_W-1:0]         mid;
    logic signed [POS_W-1:0]  rot_x;
    logic signed [POS_W-1:0]  rot_y;

    assign accept   = in_ch.valid && in_ch.ready;
    assign is_delta = (in_ch.kind == KIND_DELTA);
    assign flags_ok = in_ch.left_ok && in_ch.right_ok;
    assign out_free = !out_valid_reg || out_ch.ready;

    // Midpoint heading, twice the heading plus the step, modulo one turn
    assign mid = {head_acc_reg[MID_W-2:0], 1'b0}
               + {{(MID_W - DHEAD_W){in_ch.delta_heading[DHEAD_W-1]}}, in_ch.delta_heading};

    mdr_cordic #(
        .CORDIC_STAGES  (CORDIC_STAGES),
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .delta_x(in_ch.delta_x),
        .delta_y(in_ch.delta_y),
        .mid    (mid),
        .last   (last),
        .rot_x  (rot_x),
        .rot_y  (rot_y)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (is_delta && flags_ok) ? ST_MUL_X : ST_PUBLISH;
                end
            end
            ST_MUL_X:   state_next = ST_MUL_Y;
            ST_MUL_Y:   state_next = ST_ROTATE;
            ST_ROTATE:
            begin
                if (last)
                begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:   state_next = ST_PUBLISH;
            ST_PUBLISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ch.ready = 1'b0;
        ctl         = '0;
        accum       = 1'b0;
        publish     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                ctl.load    = in_ch.valid && is_delta && flags_ok;
            end
            ST_MUL_X:   ctl.mul_x = 1'b1;
            ST_MUL_Y:   ctl.mul_y = 1'b1;
            ST_ROTATE:  ctl.step  = 1'b1;
            ST_ACCUM:   accum     = 1'b1;
            ST_PUBLISH: publish   = out_free;
            default:    ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold the heading step for the accumulate cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dth_reg <= in_ch.delta_heading;
        end
    end

    // Pose accumulators and status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_acc_reg    <= '0;
            y_acc_reg    <= '0;
            head_acc_reg <= '0;
            kill_reg     <= 1'b0;
            fault_reg    <= FAULT_OK;
        end
        else if (accept)
        begin
            case (in_ch.kind)
                KIND_DELTA:
                begin
                    if (flags_ok)
                    begin
                        kill_reg <= 1'b0;
                    end
                    else
                    begin
                        kill_reg <= 1'b1;
                        if (!in_ch.left_ok && !in_ch.right_ok)
                        begin
                            fault_reg <= FAULT_BOTH;
                        end
                        else if (!in_ch.left_ok)
                        begin
                            fault_reg <= FAULT_LEFT;
                        end
                        else
                        begin
                            fault_reg <= FAULT_RIGHT;
                        end
                    end
                end
                KIND_ZERO:
                begin
                    x_acc_reg    <= '0;
                    y_acc_reg    <= '0;
                    head_acc_reg <= '0;
                end
                KIND_CLEAR:
                begin
                    kill_reg  <= 1'b0;
                    fault_reg <= FAULT_OK;
                end
                default: ;
            endcase
        end
        else if (accum)
        begin
            x_acc_reg    <= x_acc_reg + rot_x;
            y_acc_reg    <= y_acc_reg + rot_y;
            head_acc_reg <= head_acc_reg
                          + {{(HEAD_W - DHEAD_W){dth_reg[DHEAD_W-1]}}, dth_reg};
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (publish)
        begin
            out_x_reg     <= x_acc_reg;
            out_y_reg     <= y_acc_reg;
            out_head_reg  <= head_acc_reg;
            out_kill_reg  <= kill_reg;
            out_fault_reg <= fault_reg;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.pos_x       = out_x_reg;
    assign out_ch.pos_y       = out_y_reg;
    assign out_ch.heading_out = out_head_reg;
    assign out_ch.killed      = out_kill_reg;
    assign out_ch.fault_code  = out_fault_reg;

`ifndef NO_ASSERTIONS
    // A good motion word clears the kill flag
    a_delta_clears_kill: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_delta && flags_ok |=> !kill_reg)
        else $error("kill flag not cleared by valid delta");

    // A sensor fault sets the kill flag with a fault code
    a_fault_latched: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_delta && !flags_ok |=> kill_reg && fault_reg != FAULT_OK)
        else $error("sensor fault not latched");

    // Clear fault empties the status
    a_clear_status: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_ch.kind == KIND_CLEAR |=> !kill_reg && fault_reg == FAULT_OK)
        else $error("status not cleared");

    // The last rotation step hands over to accumulate
    a_rotate_to_accum: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROTATE && last |=> state_reg == ST_ACCUM)
        else $error("rotation did not end in accumulate");

    // The heading moves only on accumulate or pose zero
    a_heading_source: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(head_acc_reg) |->
            $past(state_reg == ST_ACCUM) || $past(accept && in_ch.kind == KIND_ZERO))
        else $error("heading changed outside accumulate");
`endif

endmodule
